// File: rtl/core/uart_drb_pkg.sv
// Shared types and constants of the UART dual ring buffer.
// Used by the channel interfaces, the control engine and the top level.
package uart_drb_pkg;

   localparam int RING_DEPTH = 256;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int SIZE_W     = $clog2(RING_DEPTH + 1);
   localparam int BYTE_W     = 8;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 8;
   localparam int TALLY_W    = 32;
   localparam int NUM_TALLY  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RX_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_SIZE = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_RX_BYTE    = 3'd0,
      CMD_TX_READY   = 3'd1,
      CMD_HOST_WRITE = 3'd2,
      CMD_HOST_READ  = 3'd3,
      CMD_RX_PURGE   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 3'd0,
      STS_RX_FULL    = 3'd1,
      STS_RX_ERROR   = 3'd2,
      STS_READ_EMPTY = 3'd3,
      STS_WRITE_FULL = 3'd4,
      STS_TX_IDLE    = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] line_byte;
      logic              framing_flag;
      logic              parity_flag;
      logic              noise_flag;
      logic              overrun_flag;
      logic [BYTE_W-1:0] host_byte;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   read_byte;
      logic                send_valid;
      logic [BYTE_W-1:0]   send_byte;
      logic                tx_irq_enabled;
      logic [COUNT_W-1:0]  rx_used;
      logic [COUNT_W-1:0]  tx_free;
      logic [TALLY_W-1:0]  framing_errors;
      logic [TALLY_W-1:0]  parity_errors;
      logic [TALLY_W-1:0]  noise_errors;
      logic [TALLY_W-1:0]  overrun_errors;
   } rsp_beat_type;

   typedef struct packed {
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } mem_req_type;

endpackage

// File: rtl/core/uart_drb_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on uart_drb_pkg for the beat types.
interface uart_drb_req_if import uart_drb_pkg::*; ();
   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface uart_drb_rsp_if import uart_drb_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/uart_drb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package dependency.
module uart_drb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/uart_drb_ctrl.sv
// Control engine: ring pointers, size registers, error tallies and the item sequencer.
// Depends on uart_drb_pkg; drives the two ring memories through mem_req_type.
module uart_drb_ctrl import uart_drb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_beat_type          req_data,
   output logic                  res_valid,
   input  logic                  res_take,
   output rsp_beat_type          res_data,
   output mem_req_type           rx_mem,
   input  logic [BYTE_W-1:0]     rx_rd_data,
   output mem_req_type           tx_mem,
   input  logic [BYTE_W-1:0]     tx_rd_data
);

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] res;
      if (raw < SIZE_W'(2)) begin
         res = SIZE_W'(2);
      end else if (raw > SIZE_W'(RING_DEPTH)) begin
         res = SIZE_W'(RING_DEPTH);
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] nxt;
      nxt = SIZE_W'(ptr) + SIZE_W'(1);
      return (nxt >= size) ? '0 : nxt[PTR_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] used_count(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail,
                                                    input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] res;
      if (head >= tail) begin
         res = SIZE_W'(head) - SIZE_W'(tail);
      end else begin
         res = SIZE_W'(head) + size - SIZE_W'(tail);
      end
      return res;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [SIZE_W-1:0] value);
      return (value > SIZE_W'({COUNT_W{1'b1}})) ? '1 : value[COUNT_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   rx_size_ff, rx_size_in;
   logic [SIZE_W-1:0]   tx_size_ff, tx_size_in;
   logic [PTR_W-1:0]    rx_head_ff, rx_head_in;
   logic [PTR_W-1:0]    rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0]    tx_head_ff, tx_head_in;
   logic [PTR_W-1:0]    tx_tail_ff, tx_tail_in;
   logic [TALLY_W-1:0]  tally_ff [NUM_TALLY];
   logic [TALLY_W-1:0]  tally_in [NUM_TALLY];
   logic                tx_irq_ff, tx_irq_in;
   status_type          pend_status_ff, pend_status_in;
   logic                pend_read_ff, pend_read_in;
   logic                pend_send_ff, pend_send_in;

   logic                accept;
   logic [SIZE_W-1:0]   rx_eff;
   logic [SIZE_W-1:0]   tx_eff;
   logic [PTR_W-1:0]    rx_head_next;
   logic [PTR_W-1:0]    rx_tail_next;
   logic [PTR_W-1:0]    tx_head_next;
   logic [PTR_W-1:0]    tx_tail_next;
   logic                any_error;
   logic [NUM_TALLY-1:0] err_flags;

   assign accept       = req_valid && req_ready;
   assign rx_eff       = eff_size(rx_size_ff);
   assign tx_eff       = eff_size(tx_size_ff);
   assign rx_head_next = advance(rx_head_ff, rx_eff);
   assign rx_tail_next = advance(rx_tail_ff, rx_eff);
   assign tx_head_next = advance(tx_head_ff, tx_eff);
   assign tx_tail_next = advance(tx_tail_ff, tx_eff);
   assign err_flags    = {req_data.overrun_flag, req_data.noise_flag,
                          req_data.parity_flag, req_data.framing_flag};
   assign any_error    = |err_flags;

   always_comb begin
      rx_size_in     = rx_size_ff;
      tx_size_in     = tx_size_ff;
      rx_head_in     = rx_head_ff;
      rx_tail_in     = rx_tail_ff;
      tx_head_in     = tx_head_ff;
      tx_tail_in     = tx_tail_ff;
      tally_in       = tally_ff;
      tx_irq_in      = tx_irq_ff;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      pend_send_in   = pend_send_ff;

      rx_mem         = '0;
      rx_mem.rd_addr = rx_tail_ff;
      rx_mem.wr_addr = rx_head_ff;
      rx_mem.wr_data = req_data.line_byte;
      tx_mem         = '0;
      tx_mem.rd_addr = tx_tail_ff;
      tx_mem.wr_addr = tx_head_ff;
      tx_mem.wr_data = req_data.host_byte;

      if (csr_write_enable) begin
         if (csr_index == CSR_RX_SIZE) begin
            rx_size_in = csr_write_data;
            rx_head_in = '0;
            rx_tail_in = '0;
         end else begin
            tx_size_in = csr_write_data;
            tx_head_in = '0;
            tx_tail_in = '0;
         end
      end else if (accept) begin
         pend_status_in = STS_OK;
         pend_read_in   = 1'b0;
         pend_send_in   = 1'b0;
         case (req_data.command)
            CMD_RX_BYTE: begin
               if (any_error) begin
                  for (int i = 0; i < NUM_TALLY; i++) begin
                     if (err_flags[i]) begin
                        tally_in[i] = tally_ff[i] + TALLY_W'(1);
                     end
                  end
                  pend_status_in = STS_RX_ERROR;
               end else if (rx_head_next == rx_tail_ff) begin
                  pend_status_in = STS_RX_FULL;
               end else begin
                  rx_mem.wr_en = 1'b1;
                  rx_head_in   = rx_head_next;
               end
            end
            CMD_TX_READY: begin
               if (tx_head_ff == tx_tail_ff) begin
                  tx_irq_in      = 1'b0;
                  pend_status_in = STS_TX_IDLE;
               end else begin
                  tx_mem.rd_en = 1'b1;
                  pend_send_in = 1'b1;
                  tx_tail_in   = tx_tail_next;
               end
            end
            CMD_HOST_WRITE: begin
               if (tx_head_next == tx_tail_ff) begin
                  pend_status_in = STS_WRITE_FULL;
               end else begin
                  tx_mem.wr_en = 1'b1;
                  tx_head_in   = tx_head_next;
                  tx_irq_in    = 1'b1;
               end
            end
            CMD_HOST_READ: begin
               if (rx_head_ff == rx_tail_ff) begin
                  pend_status_in = STS_READ_EMPTY;
               end else begin
                  rx_mem.rd_en = 1'b1;
                  pend_read_in = 1'b1;
                  rx_tail_in   = rx_tail_next;
               end
            end
            CMD_RX_PURGE: begin
               rx_head_in = '0;
               rx_tail_in = '0;
            end
            default: begin
               pend_status_in = STS_OK;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      res_data                = '0;
      res_data.status         = pend_status_ff;
      res_data.read_byte      = pend_read_ff ? rx_rd_data : '0;
      res_data.send_valid     = pend_send_ff;
      res_data.send_byte      = pend_send_ff ? tx_rd_data : '0;
      res_data.tx_irq_enabled = tx_irq_ff;
      res_data.rx_used        = sat_count(used_count(rx_head_ff, rx_tail_ff, rx_eff));
      res_data.tx_free        = sat_count(tx_eff - SIZE_W'(1)
                                          - used_count(tx_head_ff, tx_tail_ff, tx_eff));
      res_data.framing_errors = tally_ff[0];
      res_data.parity_errors  = tally_ff[1];
      res_data.noise_errors   = tally_ff[2];
      res_data.overrun_errors = tally_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rx_size_ff <= SIZE_W'(RING_DEPTH);
         tx_size_ff <= SIZE_W'(RING_DEPTH);
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         tx_irq_ff  <= 1'b1;
         for (int i = 0; i < NUM_TALLY; i++) begin
            tally_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rx_size_ff <= rx_size_in;
         tx_size_ff <= tx_size_in;
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         tx_irq_ff  <= tx_irq_in;
         tally_ff   <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      pend_send_ff   <= pend_send_in;
   end

   // Pointers must stay inside the configured ring.
   assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(rx_head_ff) < rx_eff && SIZE_W'(rx_tail_ff) < rx_eff)
      else $error("receive pointer outside ring");

   assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(tx_head_ff) < tx_eff && SIZE_W'(tx_tail_ff) < tx_eff)
      else $error("transmit pointer outside ring");

   // A store into the transmit ring never overruns its tail.
   assert property (@(posedge clock) disable iff (reset)
      tx_mem.wr_en |-> tx_head_next != tx_tail_ff)
      else $error("transmit ring overwritten while full");

   // Memory reads are issued only when an item is taken, and the result follows.
   assert property (@(posedge clock) disable iff (reset)
      (rx_mem.rd_en || tx_mem.rd_en) |-> accept)
      else $error("ring read outside an accepted beat");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> res_valid)
      else $error("accepted beat produced no result");

endmodule

// File: rtl/core/uart_drb_ring_buffer_top.sv
// A request beat accepted on the request channel has its response registered in the control engine
// and then in the response register before it is offered; a stalled response channel holds it there.
// No new request beat is taken until the last response has passed into the response register.
// Reset (synchronous, active high): both ring sizes 256, all pointers and error
// counts zero, transmit interrupt enable set; the ring memories are not cleared.
module uart_dual_ring_buffer_top import uart_drb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   uart_drb_req_if.sink          req_chan,
   uart_drb_rsp_if.source        rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   mem_req_type          rx_mem;
   mem_req_type          tx_mem;
   logic [BYTE_W-1:0]    rx_rd_data;
   logic [BYTE_W-1:0]    tx_rd_data;
   logic                 res_valid;
   logic                 res_take;
   rsp_beat_type         res_data;
   logic                 req_ready;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_data_ff;

   uart_drb_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_chan.valid),
      .req_ready        (req_ready),
      .req_data         (req_chan.data),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res_data         (res_data),
      .rx_mem           (rx_mem),
      .rx_rd_data       (rx_rd_data),
      .tx_mem           (tx_mem),
      .tx_rd_data       (tx_rd_data)
   );

   uart_drb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_mem.wr_en),
      .wr_addr (rx_mem.wr_addr),
      .wr_data (rx_mem.wr_data),
      .rd_en   (rx_mem.rd_en),
      .rd_addr (rx_mem.rd_addr),
      .rd_data (rx_rd_data)
   );

   uart_drb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_mem.wr_en),
      .wr_addr (tx_mem.wr_addr),
      .wr_data (tx_mem.wr_data),
      .rd_en   (tx_mem.rd_en),
      .rd_addr (tx_mem.rd_addr),
      .rd_data (tx_rd_data)
   );

   assign req_chan.ready = req_ready;
   assign res_take       = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
